// File: hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
package sha1_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 512;
   localparam int unsigned CHAIN_N = 5;

   localparam logic [1:0] FUNC_ABSORB = 2'd0;
   localparam logic [1:0] FUNC_LAST   = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;

   localparam logic [5:0] FILL_BLOCK_END = 6'd63;
   localparam logic [5:0] FILL_LEN_NEXT  = 6'd55;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [6:0] ROUND_F2   = 7'd20;
   localparam logic [6:0] ROUND_F3   = 7'd40;
   localparam logic [6:0] ROUND_F4   = 7'd60;

   localparam logic [2:0] WORD_LAST = 3'd4;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [31:0] INIT_CHAIN [CHAIN_N] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_LEN,
      ST_START,
      ST_ROUND,
      ST_FOLD,
      ST_LOAD
   } sha1_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ABSORB,
      OP_PAD80,
      OP_PADZ,
      OP_LEN,
      OP_INIT,
      OP_ROUND,
      OP_FOLD,
      OP_LOAD
   } sha1_op_type;

   typedef struct packed {
      logic block_end;
      logic len_next;
      logic round_end;
      logic out_busy;
   } sha1_stat_type;

endpackage

// File: hdl/sha1_ctrl.sv
// Sequencer for absorb, padding, compression rounds and digest hand-off.
module sha1_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_func,
   output logic                   req_ready,
   input  sha1_pkg::sha1_stat_type stat,
   output sha1_pkg::sha1_op_type  op
);
   import sha1_pkg::*;

   sha1_state_type state_ff, state_in;
   logic fin_ff, fin_in;
   logic sent_ff, sent_in;
   logic done_ff, done_in;
   logic accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         sent_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         sent_ff  <= sent_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      sent_in  = sent_ff;
      done_in  = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ABSORB: begin
                     if (stat.block_end) state_in = ST_START;
                  end
                  FUNC_LAST: begin
                     fin_in   = 1'b1;
                     state_in = stat.block_end ? ST_START : ST_PAD80;
                  end
                  FUNC_FINISH: begin
                     fin_in   = 1'b1;
                     state_in = ST_PAD80;
                  end
                  default: ;
               endcase
            end
         end
         ST_PAD80, ST_PADZ: begin
            if (state_ff == ST_PAD80) sent_in = 1'b1;
            priority if (stat.block_end) state_in = ST_START;
            else if (stat.len_next) state_in = ST_LEN;
            else state_in = ST_PADZ;
         end
         ST_LEN: begin
            done_in  = 1'b1;
            state_in = ST_START;
         end
         ST_START: state_in = ST_ROUND;
         ST_ROUND: begin
            if (stat.round_end) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            priority if (!fin_ff) state_in = ST_IDLE;
            else if (done_ff) state_in = ST_LOAD;
            else if (sent_ff) state_in = ST_PADZ;
            else state_in = ST_PAD80;
         end
         ST_LOAD: begin
            if (!stat.out_busy) begin
               fin_in   = 1'b0;
               sent_in  = 1'b0;
               done_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      op        = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && (req_func == FUNC_ABSORB || req_func == FUNC_LAST)) op = OP_ABSORB;
         end
         ST_PAD80: op = OP_PAD80;
         ST_PADZ:  op = OP_PADZ;
         ST_LEN:   op = OP_LEN;
         ST_START: op = OP_INIT;
         ST_ROUND: op = OP_ROUND;
         ST_FOLD:  op = OP_FOLD;
         ST_LOAD: begin
            if (!stat.out_busy) op = OP_LOAD;
         end
         default: op = OP_NONE;
      endcase
   end

endmodule

// File: hdl/sha1_dp.sv
// Block shift line, round unit, chaining words, counters and digest output register.
module sha1_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  sha1_pkg::sha1_op_type   op,
   input  logic [7:0]              req_data,
   output sha1_pkg::sha1_stat_type stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_digest_word,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word
);
   import sha1_pkg::*;

   logic [BLOCK_W-1:0] blk_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] chain_ff [CHAIN_N];
   logic [6:0]  round_ff;
   logic [63:0] count_ff;
   logic [5:0]  fill_ff;
   logic [159:0] dig_ff;
   logic [2:0]  idx_ff;
   logic        ovld_ff;

   logic [31:0] w, wx, wn, f, k, t;

   assign w  = blk_ff[511:480];
   assign wx = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ w;
   assign wn = {wx[30:0], wx[31]};

   always_comb begin
      priority if (round_ff < ROUND_F2) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (round_ff < ROUND_F3) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (round_ff < ROUND_F4) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
   end

   assign t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w;

   always_ff @(posedge clock) begin
      unique case (op)
         OP_ABSORB: blk_ff <= {blk_ff[503:0], req_data};
         OP_PAD80:  blk_ff <= {blk_ff[503:0], PAD_MARK};
         OP_PADZ:   blk_ff <= {blk_ff[503:0], PAD_ZERO};
         OP_LEN:    blk_ff <= {blk_ff[447:0], count_ff[60:0], 3'b000};
         OP_ROUND:  blk_ff <= {blk_ff[479:0], wn};
         default: ;
      endcase
      if (op == OP_INIT) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (op == OP_ROUND) begin
         a_ff <= t;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAIN_N; i++) chain_ff[i] <= INIT_CHAIN[i];
         round_ff <= '0;
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         unique case (op)
            OP_ABSORB: begin
               count_ff <= count_ff + 64'd1;
               fill_ff  <= fill_ff + 6'd1;
            end
            OP_PAD80, OP_PADZ: fill_ff <= fill_ff + 6'd1;
            OP_LEN:   fill_ff <= '0;
            OP_INIT:  round_ff <= '0;
            OP_ROUND: round_ff <= round_ff + 7'd1;
            OP_FOLD: begin
               chain_ff[0] <= chain_ff[0] + a_ff;
               chain_ff[1] <= chain_ff[1] + b_ff;
               chain_ff[2] <= chain_ff[2] + c_ff;
               chain_ff[3] <= chain_ff[3] + d_ff;
               chain_ff[4] <= chain_ff[4] + e_ff;
            end
            OP_LOAD: begin
               for (int i = 0; i < CHAIN_N; i++) chain_ff[i] <= INIT_CHAIN[i];
               count_ff <= '0;
               fill_ff  <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_LOAD) begin
         dig_ff <= {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3], chain_ff[4]};
      end else if (ovld_ff && rsp_ready) begin
         dig_ff <= {dig_ff[127:0], 32'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (op == OP_LOAD) begin
         ovld_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (ovld_ff && rsp_ready) begin
         idx_ff <= idx_ff + 3'd1;
         if (idx_ff == WORD_LAST) ovld_ff <= 1'b0;
      end
   end

   assign stat.block_end = (fill_ff == FILL_BLOCK_END);
   assign stat.len_next  = (fill_ff == FILL_LEN_NEXT);
   assign stat.round_end = (round_ff == ROUND_LAST);
   assign stat.out_busy  = ovld_ff;

   assign rsp_valid       = ovld_ff;
   assign rsp_digest_word = dig_ff[159:128];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == WORD_LAST);

endmodule

// File: hdl/sha1_stream_hasher.sv
// SHA-1 stream hasher top level: sequencer plus datapath.
//
//  channel | direction | ports                                           | moves
//  req     | in        | req_valid req_ready req_data req_func           | one byte/command item
//  rsp     | out       | rsp_valid rsp_ready rsp_digest_word             | one digest word item
//          |           | rsp_word_index rsp_last_word                    |
//
// An absorb item is taken while idle; the 64th byte of a block starts a compression
// (load, 80 rounds at one round per cycle, chain fold).
// A finish pads one byte per cycle and compresses one or two
// blocks, then loads the digest register; five rsp items follow.
// New items are taken while the digest drains; a second finish's digest load waits for it.
// Reset is synchronous and restores the initial chaining words and counters.
module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data,
   input  logic [1:0]  req_func,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1_pkg::*;

   sha1_op_type   op;
   sha1_stat_type stat;

   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   sha1_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .req_data        (req_data),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   a_no_req_in_rounds: assert property (@(posedge clock) disable iff (reset)
      (op == OP_ROUND) |-> !req_ready)
      else $error("input taken during compression");

   a_last_ends_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> !rsp_valid)
      else $error("digest output continues after last word");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word order broken");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD) |-> !rsp_valid)
      else $error("digest loaded over pending output");

endmodule
